[rtl/assert_macros.svh]
// Assertion shorthands for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DEQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/deq_pkg.sv]
package deq_pkg;

	localparam int unsigned DATA_W = 32;

	// Operation codes of the kind field; the remaining codes only read.
	localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
	localparam logic [2:0] KIND_PUSH_REAR  = 3'd1;
	localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
	localparam logic [2:0] KIND_POP_REAR   = 3'd3;
	localparam logic [2:0] KIND_READ       = 3'd4;

	// Reported for both ends when the queue is empty.
	localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

	typedef struct packed {
		logic [2:0]               kind;
		logic signed [DATA_W-1:0] item_value;
	} deq_in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] front_value;
		logic signed [DATA_W-1:0] rear_value;
		logic                     is_empty;
		logic                     underflow;
		logic                     overflow;
	} deq_out_t;

endpackage

[rtl/deq_mem.sv]
module deq_mem import deq_pkg::*; #(
	parameter int DEPTH = 16,
	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [IW-1:0]     wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [IW-1:0]     rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read; data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/deq_ctrl.sv]
module deq_ctrl import deq_pkg::*; #(
	parameter int DEPTH = 16,
	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  deq_in_t           in_data,
	output logic              s1_valid,
	input  logic              s1_ready,
	output deq_out_t          s1_res,
	output logic              wr_en,
	output logic [IW-1:0]     wr_addr,
	output logic [DATA_W-1:0] wr_data,
	output logic              rd_en,
	output logic [IW-1:0]     rd_addr,
	input  logic [DATA_W-1:0] rd_data
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);
	localparam logic [CW-1:0] ONE  = CW'(1);
	localparam logic [CW-1:0] TWO  = CW'(2);

	function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] i);
		ring_next = (i == LAST) ? '0 : IW'(i + 1'b1);
	endfunction

	function automatic logic [IW-1:0] ring_prev(input logic [IW-1:0] i);
		ring_prev = (i == '0) ? LAST : IW'(i - 1'b1);
	endfunction

	logic [IW-1:0] head_q, head_d;
	logic [IW-1:0] tail_q, tail_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic          s1_valid_q;
	logic          in_fire, s1_fire;
	logic          is_full, is_none;

	// cached end values, meaningful while the queue holds items
	logic signed [DATA_W-1:0] front_q, rear_q;
	logic signed [DATA_W-1:0] nfront, nrear;
	logic                     rd_front, rd_rear, under, over;

	logic signed [DATA_W-1:0] nfront_s1, nrear_s1;
	logic                     rd_front_s1, rd_rear_s1, empty_s1, under_s1, over_s1;

	assign in_ready = !s1_valid_q;
	assign in_fire  = in_valid && in_ready;
	assign s1_fire  = s1_valid_q && s1_ready;
	assign s1_valid = s1_valid_q;
	assign is_full  = (cnt_q == FULL);
	assign is_none  = (cnt_q == '0);
	assign wr_data  = in_data.item_value;

	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		cnt_d    = cnt_q;
		wr_en    = 1'b0;
		wr_addr  = head_q;
		rd_en    = 1'b0;
		rd_addr  = head_q;
		nfront   = front_q;
		nrear    = rear_q;
		rd_front = 1'b0;
		rd_rear  = 1'b0;
		under    = 1'b0;
		over     = 1'b0;
		unique case (in_data.kind)
			KIND_PUSH_FRONT: begin
				if (is_full) begin
					over = 1'b1;
				end else begin
					head_d  = ring_prev(head_q);
					wr_en   = in_fire;
					wr_addr = ring_prev(head_q);
					cnt_d   = CW'(cnt_q + 1'b1);
					nfront  = in_data.item_value;
					if (is_none) nrear = in_data.item_value;
				end
			end
			KIND_PUSH_REAR: begin
				if (is_full) begin
					over = 1'b1;
				end else begin
					tail_d  = ring_next(tail_q);
					wr_en   = in_fire;
					wr_addr = tail_q;
					cnt_d   = CW'(cnt_q + 1'b1);
					nrear   = in_data.item_value;
					if (is_none) nfront = in_data.item_value;
				end
			end
			KIND_POP_FRONT: begin
				if (is_none) begin
					under = 1'b1;
				end else begin
					head_d = ring_next(head_q);
					cnt_d  = CW'(cnt_q - 1'b1);
					if (cnt_q == TWO) begin
						nfront = rear_q;
					end else if (cnt_q != ONE) begin
						rd_en    = in_fire;
						rd_addr  = ring_next(head_q);
						rd_front = 1'b1;
					end
				end
			end
			KIND_POP_REAR: begin
				if (is_none) begin
					under = 1'b1;
				end else begin
					tail_d = ring_prev(tail_q);
					cnt_d  = CW'(cnt_q - 1'b1);
					if (cnt_q == TWO) begin
						nrear = front_q;
					end else if (cnt_q != ONE) begin
						rd_en   = in_fire;
						rd_addr = ring_prev(ring_prev(tail_q));
						rd_rear = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= '0;
			cnt_q      <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				head_q     <= head_d;
				tail_q     <= tail_d;
				cnt_q      <= cnt_d;
				s1_valid_q <= 1'b1;
			end else if (s1_fire) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			nfront_s1   <= nfront;
			nrear_s1    <= nrear;
			rd_front_s1 <= rd_front;
			rd_rear_s1  <= rd_rear;
			empty_s1    <= (cnt_d == '0);
			under_s1    <= under;
			over_s1     <= over;
		end
	end

	always_comb begin
		s1_res.front_value = empty_s1 ? EMPTY_VALUE :
			(rd_front_s1 ? $signed(rd_data) : nfront_s1);
		s1_res.rear_value  = empty_s1 ? EMPTY_VALUE :
			(rd_rear_s1 ? $signed(rd_data) : nrear_s1);
		s1_res.is_empty    = empty_s1;
		s1_res.underflow   = under_s1;
		s1_res.overflow    = over_s1;
	end

	// end-value cache follows each completed transfer out of s1
	always_ff @(posedge clk) begin
		if (s1_fire) begin
			front_q <= s1_res.front_value;
			rear_q  <= s1_res.rear_value;
		end
	end

endmodule

[rtl/double_ended_queue_unit.sv]
// Double-ended queue of signed 32-bit items in a ring buffer of DEPTH entries.
// Each input transfer pushes at the front or rear, pops from either end, or
// only reads (kind codes 5 to 7 also only read); each gives exactly one
// result transfer carrying the front and rear items after the operation
// (-1 for both when empty), the empty flag, and underflow (pop on empty) or
// overflow (push on full, item dropped) - a failed operation changes nothing.
// The items sit in a single-port-write, single-port-read memory with a
// registered read; the two end values are also cached in registers,
// so only a pop that uncovers an older item reads the memory.
// An accepted item is held in the s1 stage, covering the memory read, and the
// next item is taken once s1 has passed its result to the output register;
// a stalled output holds s1 and with it the input. The result moves from s1
// into the output register. No clearing pass is needed after reset.
`include "assert_macros.svh"

module double_ended_queue_unit import deq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  deq_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output deq_out_t out_data
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic              s1_valid, s1_ready;
	deq_out_t          s1_res;
	logic              wr_en, rd_en;
	logic [IW-1:0]     wr_addr, rd_addr;
	logic [DATA_W-1:0] wr_data, rd_data;

	logic     out_valid_q;
	deq_out_t out_data_q;

	// pointers, fill count, s1 stage and end-value cache
	deq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.s1_valid (s1_valid),
		.s1_ready (s1_ready),
		.s1_res   (s1_res),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data)
	);

	// item storage
	deq_mem #(.DEPTH(DEPTH)) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// output register: s1 may load it when empty or being drained
	assign s1_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (s1_valid && s1_ready) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid && s1_ready) begin
			out_data_q <= s1_res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// an accepted item always reaches s1 on the next edge
	`DEQ_ASSERT_NEXT(a_in_to_s1, clk, arst_n, in_valid && in_ready, s1_valid, "input transfer lost before s1")

	// empty result carries the marker value at both ends
	`DEQ_ASSERT_NOW(a_empty_marker, clk, arst_n, out_valid && out_data.is_empty, (out_data.front_value == EMPTY_VALUE) && (out_data.rear_value == EMPTY_VALUE), "empty result without marker values")

	// a single operation cannot both underflow and overflow
	`DEQ_ASSERT_NOW(a_flags_excl, clk, arst_n, out_valid, !(out_data.underflow && out_data.overflow), "underflow and overflow together")

	// a blocked s1 result is kept until it moves on
	`DEQ_ASSERT_NEXT(a_s1_hold, clk, arst_n, s1_valid && !s1_ready, s1_valid && !in_ready, "s1 result dropped while output stalled")

endmodule
